// File: rtl/core/i2cerd_pkg.sv
// ----------------------------------------------------------------------------
// i2cerd_pkg
// types and constants shared by the eeprom read master
// ----------------------------------------------------------------------------
package i2cerd_pkg;

  localparam int PAGE_BYTES = 64;
  localparam int ADDR_W     = 16;
  localparam int BYTE_CNT_W = 7;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_PHASE_TICKS    = 1'b1
  } cfg_index_t;

  // bus sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE = 5'd0,
    ST_SA   = 5'd1,
    ST_SB   = 5'd2,
    ST_SC   = 5'd3,
    ST_SD   = 5'd4,
    ST_WLO  = 5'd5,
    ST_WHI  = 5'd6,
    ST_WALO = 5'd7,
    ST_WAHI = 5'd8,
    ST_RLO  = 5'd9,
    ST_RHI  = 5'd10,
    ST_RALO = 5'd11,
    ST_RAHI = 5'd12
  } step_t;

  typedef struct packed {
    logic              start_request;
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic              sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       busy_res;
    logic       no_ack;
  } out_t;

endpackage

// File: rtl/core/i2c_eeprom_read_master.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_read_master
// i2c master for a 16-bit-addressed eeprom: random byte read and page read
// ----------------------------------------------------------------------------
//
//  channel | direction | payload          | transaction
//  --------+-----------+------------------+-------------------------------
//  in_     | input     | i2cerd_pkg::in_t | one bus timing tick
//  out_    | output    | i2cerd_pkg::out_t| bus levels and status per tick
//  cfg_    | input     | index + 8b data  | one register write
//
//  one tick is taken per clock; its result is in the output register on the
//  next cycle, and the sequencer logic sits between the state registers and
//  that output register
//  a new tick is accepted while the output register is empty or being taken
//  reset (synchronous, rst_n low) returns the sequencer to idle with the bus
//  released and the registers at their defaults; cfg_ready is always high
//
module i2c_eeprom_read_master (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  i2cerd_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cerd_pkg::out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [7:0]       cfg_data
);
  import i2cerd_pkg::*;

  // configuration registers
  logic [6:0] dev_addr_r;
  logic [7:0] phase_ticks_r;

  // sequencer state
  step_t                 step_r, step_nxt;
  logic [3:0]            bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]            tick_cnt_r, tick_cnt_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic                  page_mode_r, page_mode_nxt;
  logic                  nack_r, nack_nxt;

  // output register
  logic out_valid_r;
  out_t out_data_r, res;

  // state after a possible start this tick
  step_t                 cur_step;
  logic [BYTE_CNT_W-1:0] cur_byte_cnt;
  logic [3:0]            cur_bit_cnt;
  logic [7:0]            cur_tick_cnt;
  logic [7:0]            cur_shift;
  logic [ADDR_W-1:0]     cur_addr;
  logic                  cur_page_mode;
  logic                  cur_nack;

  logic       scl, pull;
  logic       last_rd;
  logic [7:0] phase_len;
  logic [8:0] tick_inc;
  logic       phase_end;
  logic [3:0] bit_inc;
  logic [7:0] rd_shift;
  logic       rd_valid;
  logic       in_fire;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // start handling: an idle (or unknown) step picks up a request at once
  always_comb begin
    cur_step      = step_r;
    cur_byte_cnt  = byte_cnt_r;
    cur_bit_cnt   = bit_cnt_r;
    cur_tick_cnt  = tick_cnt_r;
    cur_shift     = shift_r;
    cur_addr      = addr_r;
    cur_page_mode = page_mode_r;
    cur_nack      = nack_r;
    if (step_r == ST_IDLE || step_r > ST_RAHI) begin
      cur_step = ST_IDLE;
      if (in_data.start_request) begin
        cur_page_mode = in_data.operation;
        // page index scaled to a byte address, low bits kept
        cur_addr      = in_data.operation ?
                        ADDR_W'(in_data.address * ADDR_W'(PAGE_BYTES)) : in_data.address;
        cur_nack      = 1'b0;
        cur_byte_cnt  = '0;
        cur_bit_cnt   = '0;
        cur_tick_cnt  = '0;
        cur_shift     = {dev_addr_r, 1'b0};
        cur_step      = ST_SA;
      end
    end
  end

  // last read byte: always in single mode, final page byte in page mode
  assign last_rd = !cur_page_mode || (cur_byte_cnt == BYTE_CNT_W'(PAGE_BYTES - 1));

  // bus levels for the current step
  always_comb begin
    case (cur_step)
      ST_SA:   begin scl = 1'b0; pull = 1'b0; end
      ST_SB:   begin scl = 1'b1; pull = 1'b0; end
      ST_SC:   begin scl = 1'b1; pull = 1'b1; end
      ST_SD:   begin scl = 1'b0; pull = 1'b1; end
      ST_WLO:  begin scl = 1'b0; pull = !cur_shift[7]; end
      ST_WHI:  begin scl = 1'b1; pull = !cur_shift[7]; end
      ST_WALO, ST_RLO: begin scl = 1'b0; pull = 1'b0; end
      ST_WAHI, ST_RHI: begin scl = 1'b1; pull = 1'b0; end
      // ack driven low except after the last byte
      ST_RALO: begin scl = 1'b0; pull = !last_rd; end
      ST_RAHI: begin scl = 1'b1; pull = !last_rd; end
      default: begin scl = 1'b1; pull = 1'b0; end
    endcase
  end

  // phase timer; a phase length of zero behaves as one
  assign phase_len = (phase_ticks_r == 8'd0) ? 8'd1 : phase_ticks_r;
  assign tick_inc  = {1'b0, cur_tick_cnt} + 9'd1;
  assign phase_end = (cur_step != ST_IDLE) && (tick_inc >= {1'b0, phase_len});
  assign bit_inc   = cur_bit_cnt + 4'd1;
  assign rd_shift  = {cur_shift[6:0], in_data.sda_in};

  // next step and datapath
  always_comb begin
    step_nxt      = cur_step;
    bit_cnt_nxt   = cur_bit_cnt;
    byte_cnt_nxt  = cur_byte_cnt;
    tick_cnt_nxt  = cur_tick_cnt;
    shift_nxt     = cur_shift;
    addr_nxt      = cur_addr;
    page_mode_nxt = cur_page_mode;
    nack_nxt      = cur_nack;
    rd_valid      = 1'b0;
    if (cur_step != ST_IDLE) begin
      tick_cnt_nxt = phase_end ? 8'd0 : tick_inc[7:0];
    end
    if (phase_end) begin
      case (cur_step)
        ST_SA: step_nxt = ST_SB;
        ST_SB: step_nxt = ST_SC;
        ST_SC: step_nxt = ST_SD;
        ST_SD: begin
          bit_cnt_nxt = '0;
          step_nxt    = ST_WLO;
        end
        ST_WLO: step_nxt = ST_WHI;
        ST_WHI: begin
          shift_nxt   = {cur_shift[6:0], 1'b0};
          bit_cnt_nxt = bit_inc;
          step_nxt    = (bit_inc >= 4'd8) ? ST_WALO : ST_WLO;
        end
        ST_WALO: step_nxt = ST_WAHI;
        ST_WAHI: begin
          // sticky flag for a missing ack, transfer carries on
          if (in_data.sda_in) begin
            nack_nxt = 1'b1;
          end
          bit_cnt_nxt = '0;
          if (cur_byte_cnt == BYTE_CNT_W'(0)) begin
            shift_nxt    = cur_addr[15:8];
            byte_cnt_nxt = BYTE_CNT_W'(1);
            step_nxt     = ST_WLO;
          end else if (cur_byte_cnt == BYTE_CNT_W'(1)) begin
            shift_nxt    = cur_addr[7:0];
            byte_cnt_nxt = BYTE_CNT_W'(2);
            step_nxt     = ST_WLO;
          end else if (cur_byte_cnt == BYTE_CNT_W'(2)) begin
            // repeated start with the read bit
            shift_nxt    = {dev_addr_r, 1'b1};
            byte_cnt_nxt = BYTE_CNT_W'(3);
            step_nxt     = ST_SA;
          end else begin
            byte_cnt_nxt = '0;
            shift_nxt    = '0;
            step_nxt     = ST_RLO;
          end
        end
        ST_RLO: step_nxt = ST_RHI;
        ST_RHI: begin
          shift_nxt   = rd_shift;
          bit_cnt_nxt = bit_inc;
          if (bit_inc >= 4'd8) begin
            rd_valid = 1'b1;
            step_nxt = ST_RALO;
          end else begin
            step_nxt = ST_RLO;
          end
        end
        ST_RALO: step_nxt = ST_RAHI;
        ST_RAHI: begin
          if (last_rd) begin
            step_nxt     = ST_IDLE;
            byte_cnt_nxt = '0;
          end else begin
            byte_cnt_nxt = cur_byte_cnt + BYTE_CNT_W'(1);
            step_nxt     = ST_RLO;
          end
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
        end
        default: step_nxt = ST_IDLE;
      endcase
    end
  end

  // result of this tick
  always_comb begin
    res.scl_level    = scl;
    res.sda_pull_low = pull;
    res.byte_valid   = rd_valid;
    res.byte_value   = rd_valid ? rd_shift : 8'd0;
    res.last_byte    = rd_valid && last_rd;
    res.busy_res     = (step_nxt != ST_IDLE) || rd_valid;
    res.no_ack       = nack_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= 7'd80;
      phase_ticks_r <= 8'd2;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_DEVICE_ADDRESS: dev_addr_r    <= cfg_data[6:0];
        CFG_PHASE_TICKS:    phase_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      tick_cnt_r  <= '0;
      shift_r     <= '0;
      addr_r      <= '0;
      page_mode_r <= 1'b0;
      nack_r      <= 1'b0;
    end else if (in_fire) begin
      step_r      <= step_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      shift_r     <= shift_nxt;
      addr_r      <= addr_nxt;
      page_mode_r <= page_mode_nxt;
      nack_r      <= nack_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

endmodule
